>>> design/sps_pkg.sv
// shared constants, types and helpers for the prime sieve pipeline
`default_nettype none

package sps_pkg;

    localparam int NUM_STAGES  = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int FIELD_W     = 16;
    localparam int KIND_W      = 2;
    localparam int CNT_W       = $clog2(NUM_STAGES + 1);
    localparam int BCNT_W      = $clog2(VALUE_WIDTH);

    localparam logic [KIND_W-1:0] KIND_PRIME = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    typedef logic [VALUE_WIDTH-1:0] val_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_FINISH
    } sps_state_t;

    // one bit of a number moving down the chain, msb first
    typedef struct packed {
        logic vld;
        logic dbit;
        logic start;
        logic last;
        logic hit;
    } sps_stream_t;

    // store command broadcast from the controller
    typedef struct packed {
        logic             clear;
        logic             write;
        logic [CNT_W-1:0] idx;
        val_t             value;
    } sps_store_t;

    // per-cell view of the store command
    typedef struct packed {
        logic clear;
        logic write;
        val_t value;
    } sps_cell_cmd_t;

    function automatic val_t field_to_val(input logic [FIELD_W-1:0] f);
        return VALUE_WIDTH'(f);
    endfunction

    function automatic logic [FIELD_W-1:0] val_to_field(input val_t v);
        return FIELD_W'(v);
    endfunction

endpackage

`default_nettype wire

>>> design/sps_in_if.sv
// input channel of the prime sieve pipeline
`default_nettype none

interface sps_in_if;
    logic                        valid;
    logic                        ready;
    logic [sps_pkg::FIELD_W-1:0] number;
    logic                        end_of_stream;

    modport source (output valid, output number, output end_of_stream, input ready);
    modport sink   (input valid, input number, input end_of_stream, output ready);
endinterface

`default_nettype wire

>>> design/sps_out_if.sv
// result channel of the prime sieve pipeline
`default_nettype none

interface sps_out_if;
    logic                        valid;
    logic                        ready;
    logic [sps_pkg::FIELD_W-1:0] value;
    logic [sps_pkg::KIND_W-1:0]  kind;

    modport source (output valid, output value, output kind, input ready);
    modport sink   (input valid, input value, input kind, output ready);
endinterface

`default_nettype wire

>>> design/prime_sieve_pipeline.sv
// top level of the prime sieve pipeline: sequencer and chain of sieve cells
//
// Each accepted number is shifted msb first into a chain of NUM_STAGES cells; every cell
// holds at most one stored prime and runs one restoring remainder step per cycle on the bits
// as they pass, handing the bit and a running "divided" flag to its neighbor. The verdict
// leaves the last cell's register while the sequencer drains; in the finish state a number
// that no stored prime divides has its result written to the output register, a divided one
// gives none, and the next number is taken back in idle. The time a number holds the block is
// set by the bit-serial remainder and the register hop in each cell; only one number is in the
// chain at a time. An end of stream item clears all cells at once. Results sit in an output
// register, so the next number is accepted while a result still waits for its transfer; a
// result that finds that register still full waits until the old result is taken.
`default_nettype none

module prime_sieve_pipeline (
    input  wire       clk,
    input  wire       rst_n,
    sps_in_if.sink    items,
    sps_out_if.source results
);

    sps_pkg::sps_stream_t   chain [sps_pkg::NUM_STAGES+1];
    sps_pkg::sps_store_t    store;
    sps_pkg::sps_cell_cmd_t cmd [sps_pkg::NUM_STAGES];

    sps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .inject  (chain[0]),
        .tail    (chain[sps_pkg::NUM_STAGES]),
        .store   (store)
    );

    for (genvar k = 0; k < sps_pkg::NUM_STAGES; k++)
    begin : g_cell
        // each cell takes the shared clear and the store write addressed to its slot
        always_comb
        begin
            cmd[k].clear = store.clear;
            cmd[k].write = store.write && (store.idx == sps_pkg::CNT_W'(k));
            cmd[k].value = store.value;
        end

        sps_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .up    (chain[k]),
            .cmd   (cmd[k]),
            .dn    (chain[k+1])
        );
    end

endmodule

`default_nettype wire

>>> design/sps_cell.sv
// one sieve stage: stored prime plus a bit-serial remainder step
`default_nettype none

module sps_cell (
    input  wire                   clk,
    input  wire                   rst_n,
    input  sps_pkg::sps_stream_t  up,
    input  sps_pkg::sps_cell_cmd_t cmd,
    output sps_pkg::sps_stream_t  dn
);

    sps_pkg::val_t        prime_reg;
    logic                 filled_reg;
    sps_pkg::val_t        rem_reg;
    sps_pkg::val_t        rem_next;
    sps_pkg::sps_stream_t dn_reg;
    sps_pkg::sps_stream_t dn_next;

    logic [sps_pkg::VALUE_WIDTH:0] shifted;
    logic [sps_pkg::VALUE_WIDTH:0] diff;
    sps_pkg::val_t                 rem_base;
    logic                          hit_here;

    // restoring remainder step; a stored zero leaves the prefix of n, zero only for n == 0
    always_comb
    begin
        rem_base = up.start ? '0 : rem_reg;
        shifted  = {rem_base, up.dbit};
        diff     = shifted - {1'b0, prime_reg};
        if (shifted >= {1'b0, prime_reg})
        begin
            rem_next = diff[sps_pkg::VALUE_WIDTH-1:0];
        end
        else
        begin
            rem_next = shifted[sps_pkg::VALUE_WIDTH-1:0];
        end
        hit_here = up.vld && up.last && filled_reg && (rem_next == '0);
        dn_next       = up;
        dn_next.hit   = up.hit || hit_here;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            dn_reg     <= '0;
        end
        else
        begin
            dn_reg <= dn_next;
            if (cmd.clear)
            begin
                filled_reg <= 1'b0;
            end
            else if (cmd.write)
            begin
                filled_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            prime_reg <= cmd.value;
        end
        if (up.vld)
        begin
            rem_reg <= rem_next;
        end
    end

    assign dn = dn_reg;

endmodule

`default_nettype wire

>>> design/sps_ctrl.sv
// sequencer: feeds numbers into the chain, collects the verdict, stores primes, emits results
`default_nettype none

module sps_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    sps_in_if.sink               items,
    sps_out_if.source            results,
    output sps_pkg::sps_stream_t inject,
    input  sps_pkg::sps_stream_t tail,
    output sps_pkg::sps_store_t  store
);

    localparam logic [sps_pkg::BCNT_W-1:0] LAST_BIT = sps_pkg::BCNT_W'(sps_pkg::VALUE_WIDTH - 1);
    localparam logic [sps_pkg::CNT_W-1:0]  FULL_CNT = sps_pkg::CNT_W'(sps_pkg::NUM_STAGES);

    sps_pkg::sps_state_t state_reg;
    sps_pkg::sps_state_t state_next;

    sps_pkg::val_t                  num_reg;
    sps_pkg::val_t                  shift_reg;
    logic [sps_pkg::BCNT_W-1:0]     bcnt_reg;
    logic                           eos_reg;
    logic                           hit_reg;
    logic [sps_pkg::CNT_W-1:0]      count_reg;
    logic                           out_valid_reg;
    logic [sps_pkg::FIELD_W-1:0]    out_value_reg;
    logic [sps_pkg::KIND_W-1:0]     out_kind_reg;

    logic in_xfer;
    logic emit;
    logic out_free;
    logic finish_go;
    logic has_room;

    assign in_xfer  = items.valid && items.ready;
    assign emit     = eos_reg || !hit_reg;
    assign out_free = !out_valid_reg || results.ready;
    assign has_room = count_reg < FULL_CNT;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sps_pkg::ST_IDLE:
            begin
                if (items.valid)
                begin
                    state_next = items.end_of_stream ? sps_pkg::ST_FINISH : sps_pkg::ST_FEED;
                end
            end
            sps_pkg::ST_FEED:
            begin
                if (bcnt_reg == LAST_BIT)
                begin
                    state_next = sps_pkg::ST_DRAIN;
                end
            end
            sps_pkg::ST_DRAIN:
            begin
                if (tail.vld && tail.last)
                begin
                    state_next = sps_pkg::ST_FINISH;
                end
            end
            sps_pkg::ST_FINISH:
            begin
                if (!emit || out_free)
                begin
                    state_next = sps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sps_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        finish_go    = (state_reg == sps_pkg::ST_FINISH) && (!emit || out_free);
        inject.vld   = (state_reg == sps_pkg::ST_FEED);
        inject.dbit  = shift_reg[sps_pkg::VALUE_WIDTH-1];
        inject.start = (bcnt_reg == '0);
        inject.last  = (bcnt_reg == LAST_BIT);
        inject.hit   = 1'b0;
        store.clear  = finish_go && eos_reg;
        store.write  = finish_go && !eos_reg && !hit_reg && has_room;
        store.idx    = count_reg;
        store.value  = num_reg;
    end

    assign items.ready   = (state_reg == sps_pkg::ST_IDLE);
    assign results.valid = out_valid_reg;
    assign results.value = out_value_reg;
    assign results.kind  = out_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sps_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (store.clear)
            begin
                count_reg <= '0;
            end
            else if (store.write)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (finish_go && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            num_reg   <= sps_pkg::field_to_val(items.number);
            shift_reg <= sps_pkg::field_to_val(items.number);
            eos_reg   <= items.end_of_stream;
            bcnt_reg  <= '0;
            hit_reg   <= 1'b0;
        end
        else if (state_reg == sps_pkg::ST_FEED)
        begin
            shift_reg <= {shift_reg[sps_pkg::VALUE_WIDTH-2:0], 1'b0};
            bcnt_reg  <= bcnt_reg + 1'b1;
        end
        if ((state_reg == sps_pkg::ST_DRAIN) && tail.vld && tail.last)
        begin
            hit_reg <= tail.hit;
        end
        if (finish_go && emit)
        begin
            if (eos_reg)
            begin
                out_value_reg <= '0;
                out_kind_reg  <= sps_pkg::KIND_DONE;
            end
            else
            begin
                out_value_reg <= sps_pkg::val_to_field(num_reg);
                out_kind_reg  <= has_room ? sps_pkg::KIND_PRIME : sps_pkg::KIND_FULL;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("filled count beyond chain length");

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sps_pkg::ST_FINISH) && eos_reg && out_free |=> count_reg == '0)
        else $error("end of stream did not clear the chain");

    a_tail_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        tail.vld && tail.last |-> state_reg == sps_pkg::ST_DRAIN)
        else $error("verdict left the chain outside drain");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_kind_reg == sps_pkg::KIND_PRIME ||
                           out_kind_reg == sps_pkg::KIND_FULL ||
                           out_kind_reg == sps_pkg::KIND_DONE))
        else $error("illegal result kind");

    a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        store.write |-> has_room && !store.clear)
        else $error("store into a full chain");

endmodule

`default_nettype wire
